@@ rtl/core/ffbta_pkg.sv @@
// Shared codes and default sizes for the first-fit boundary-tag allocator.
// No dependencies.
package ffbta_pkg;

   // Request kinds
   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REALLOC = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_NOFIT   = 2'd1;
   localparam logic [1:0] STAT_NOP     = 2'd2;

   // Field widths fixed by the interface
   localparam int REQ_W = 11;
   localparam int OFF_W = 10;

   // Default heap geometry
   localparam int DEF_HEAP_BYTES   = 1024;
   localparam int DEF_ALIGN_BYTES  = 4;
   localparam int DEF_HEADER_BYTES = 12;

endpackage

@@ rtl/core/first_fit_boundary_tag_allocator.sv @@
// First-fit heap allocator with boundary tags (top level).
// Depends on ffbta_pkg and ffbta_hdr_ram.
//
//  channel  | ports                                        | handshake
//  request  | req_kind, req_request_bytes, req_block_offset, | start & !busy
//           | req_block_is_null                            |
//  response | rsp_status, rsp_result_offset, rsp_result_is_null | rsp_valid strobe
//
// One transaction at a time; busy is high from the cycle after acceptance up to
// the cycle its response strobes. A free of null or an unknown kind answers in
// the cycle after acceptance without raising busy.
// An allocate first rounds the size, then reads and checks each block header
// visited through the registered header-store read, then writes any split
// remainder, or hits the heap end when nothing fits.
// A free reads and checks each header visited up to its target (and hits the
// heap end when not found), then reads the right neighbor, checks it when there
// is one, and writes the merge. Reallocate is an allocate followed by a free.
// After reset the ST_INIT state writes the initial heap header with busy high.
// The response cannot be stalled.
module first_fit_boundary_tag_allocator #(
   parameter int HEAP_BYTES   = ffbta_pkg::DEF_HEAP_BYTES,
   parameter int ALIGN_BYTES  = ffbta_pkg::DEF_ALIGN_BYTES,
   parameter int HEADER_BYTES = ffbta_pkg::DEF_HEADER_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [ffbta_pkg::REQ_W-1:0] req_request_bytes,
   input  logic [ffbta_pkg::OFF_W-1:0] req_block_offset,
   input  logic                        req_block_is_null,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [ffbta_pkg::OFF_W-1:0] rsp_result_offset,
   output logic                        rsp_result_is_null
);

   localparam int ADDR_W = $clog2(HEAP_BYTES);
   localparam int POS_W  = $clog2(HEAP_BYTES + 1);
   localparam int SUM_W  = POS_W + 1;
   localparam int NEED_W = ffbta_pkg::REQ_W + 1;
   localparam int CW     = ((POS_W > NEED_W) ? POS_W : NEED_W) + 2;
   localparam int DW     = POS_W + 1;
   // reciprocal of the alignment, exact for every rounded-up request
   localparam int RND_SHIFT = NEED_W + 4;
   localparam int RECIP     = ((1 << RND_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int PROD_W    = RND_SHIFT + NEED_W;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_A_RND, ST_A_RD, ST_A_CHK, ST_A_SPLIT,
      ST_F_RD, ST_F_CHK, ST_F_RRD, ST_F_RCHK, ST_F_WR
   } state_type;

   state_type            state_ff;
   logic [1:0]           kind_ff;
   logic [ffbta_pkg::REQ_W-1:0] req_ff;
   logic [ffbta_pkg::OFF_W-1:0] boff_ff;
   logic                 bnull_ff;
   logic [NEED_W-1:0]    need_ff;
   logic [POS_W-1:0]     pos_ff;
   logic                 seen_ff;
   logic [POS_W-1:0]     last_pos_ff;
   logic                 last_used_ff;
   logic [POS_W-1:0]     last_size_ff;
   logic [POS_W-1:0]     acc_ff;
   logic [POS_W-1:0]     start_pos_ff;
   logic [POS_W-1:0]     rem_pos_ff;
   logic [POS_W-1:0]     rem_size_ff;
   logic [ffbta_pkg::OFF_W-1:0] new_off_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [ffbta_pkg::OFF_W-1:0] rsp_off_ff;
   logic                 rsp_null_ff;

   // header store
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DW-1:0]     wr_data;
   logic [DW-1:0]     rd_data;
   logic              h_used;
   logic [POS_W-1:0]  h_size;

   ffbta_hdr_ram #(.DEPTH(HEAP_BYTES), .DATA_W(DW)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign h_used = rd_data[DW-1];
   assign h_size = rd_data[POS_W-1:0];

   // arithmetic shared by the walks
   logic [SUM_W-1:0] pos_hdr;
   logic [SUM_W-1:0] nxt_pos;
   logic             past_end;
   logic [CW-1:0]    need_c;
   logic [CW-1:0]    size_c;
   logic             fits;
   logic             do_split;
   logic             at_target;
   logic             merge_left;
   logic [NEED_W-1:0] rnd_sum;
   logic [PROD_W-1:0] rnd_prod;
   logic [NEED_W-1:0] rnd_quot;
   logic [NEED_W-1:0] need_in;

   assign pos_hdr   = SUM_W'(pos_ff) + SUM_W'(HEADER_BYTES);
   assign nxt_pos   = pos_hdr + SUM_W'(h_size);
   assign past_end  = (SUM_W'(pos_ff) >= SUM_W'(HEAP_BYTES));
   assign need_c    = CW'(need_ff);
   assign size_c    = CW'(h_size);
   assign fits      = !h_used && (size_c >= need_c);
   assign do_split  = size_c > (need_c + CW'(HEADER_BYTES));
   assign at_target = (pos_hdr == SUM_W'(boff_ff));
   assign merge_left = seen_ff && !last_used_ff;

   // round the request up to the alignment by reciprocal multiplication
   assign rnd_sum  = NEED_W'(req_ff) + NEED_W'(ALIGN_BYTES - 1);
   assign rnd_prod = PROD_W'(rnd_sum) * PROD_W'(RECIP);
   assign rnd_quot = rnd_prod[PROD_W-1:RND_SHIFT];
   assign need_in  = rnd_quot * NEED_W'(ALIGN_BYTES);

   // header store writes
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[ADDR_W-1:0];
      wr_data = {1'b1, POS_W'(need_ff)};
      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {1'b0, POS_W'(HEAP_BYTES - HEADER_BYTES)};
         end
         ST_A_CHK: begin
            wr_en   = !past_end && fits;
            wr_data = do_split ? {1'b1, POS_W'(need_ff)} : {1'b1, h_size};
         end
         ST_A_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = rem_pos_ff[ADDR_W-1:0];
            wr_data = {1'b0, rem_size_ff};
         end
         ST_F_WR: begin
            wr_en   = 1'b1;
            wr_addr = start_pos_ff[ADDR_W-1:0];
            wr_data = {1'b0, acc_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  kind_ff  <= req_kind;
                  req_ff   <= req_request_bytes;
                  boff_ff  <= req_block_offset;
                  bnull_ff <= req_block_is_null;
                  pos_ff   <= '0;
                  seen_ff  <= 1'b0;
                  case (req_kind) inside
                     ffbta_pkg::KIND_ALLOC, ffbta_pkg::KIND_REALLOC: begin
                        state_ff <= ST_A_RND;
                     end
                     ffbta_pkg::KIND_FREE: begin
                        if (req_block_is_null) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= ffbta_pkg::STAT_NOP;
                           rsp_off_ff    <= '0;
                           rsp_null_ff   <= 1'b1;
                        end else begin
                           state_ff <= ST_F_RD;
                        end
                     end
                     default: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= ffbta_pkg::STAT_NOP;
                        rsp_off_ff    <= '0;
                        rsp_null_ff   <= 1'b1;
                     end
                  endcase
               end
            end
            // round request up to the alignment
            ST_A_RND: begin
               need_ff  <= need_in;
               state_ff <= ST_A_RD;
            end
            ST_A_RD: begin
               if (past_end) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ffbta_pkg::STAT_NOFIT;
                  if (kind_ff == ffbta_pkg::KIND_REALLOC && !bnull_ff) begin
                     rsp_off_ff  <= boff_ff;
                     rsp_null_ff <= 1'b0;
                  end else begin
                     rsp_off_ff  <= '0;
                     rsp_null_ff <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_A_CHK;
               end
            end
            // first-fit check on the header just read
            ST_A_CHK: begin
               if (fits) begin
                  new_off_ff  <= ffbta_pkg::OFF_W'(pos_hdr);
                  rem_pos_ff  <= POS_W'(pos_hdr + SUM_W'(need_ff));
                  rem_size_ff <= POS_W'(size_c - need_c - CW'(HEADER_BYTES));
                  if (do_split) begin
                     state_ff <= ST_A_SPLIT;
                  end else if (kind_ff == ffbta_pkg::KIND_REALLOC && !bnull_ff) begin
                     pos_ff   <= '0;
                     state_ff <= ST_F_RD;
                  end else begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ffbta_pkg::STAT_DONE;
                     rsp_off_ff    <= ffbta_pkg::OFF_W'(pos_hdr);
                     rsp_null_ff   <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  pos_ff   <= POS_W'(nxt_pos);
                  state_ff <= ST_A_RD;
               end
            end
            ST_A_SPLIT: begin
               if (kind_ff == ffbta_pkg::KIND_REALLOC && !bnull_ff) begin
                  pos_ff   <= '0;
                  state_ff <= ST_F_RD;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ffbta_pkg::STAT_DONE;
                  rsp_off_ff    <= new_off_ff;
                  rsp_null_ff   <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            // free: walk to the block, tracking the left neighbor
            ST_F_RD: begin
               if (past_end) begin
                  rsp_valid_ff <= 1'b1;
                  if (kind_ff == ffbta_pkg::KIND_REALLOC) begin
                     rsp_status_ff <= ffbta_pkg::STAT_DONE;
                     rsp_off_ff    <= new_off_ff;
                     rsp_null_ff   <= 1'b0;
                  end else begin
                     rsp_status_ff <= ffbta_pkg::STAT_NOP;
                     rsp_off_ff    <= '0;
                     rsp_null_ff   <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_F_CHK;
               end
            end
            ST_F_CHK: begin
               if (at_target) begin
                  if (!h_used) begin
                     rsp_valid_ff <= 1'b1;
                     if (kind_ff == ffbta_pkg::KIND_REALLOC) begin
                        rsp_status_ff <= ffbta_pkg::STAT_DONE;
                        rsp_off_ff    <= new_off_ff;
                        rsp_null_ff   <= 1'b0;
                     end else begin
                        rsp_status_ff <= ffbta_pkg::STAT_NOP;
                        rsp_off_ff    <= '0;
                        rsp_null_ff   <= 1'b1;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     if (merge_left) begin
                        acc_ff       <= POS_W'(SUM_W'(last_size_ff) + nxt_pos
                                               - SUM_W'(pos_ff));
                        start_pos_ff <= last_pos_ff;
                     end else begin
                        acc_ff       <= h_size;
                        start_pos_ff <= pos_ff;
                     end
                     pos_ff   <= POS_W'(nxt_pos);
                     state_ff <= ST_F_RRD;
                  end
               end else begin
                  seen_ff      <= 1'b1;
                  last_pos_ff  <= pos_ff;
                  last_used_ff <= h_used;
                  last_size_ff <= h_size;
                  pos_ff       <= POS_W'(nxt_pos);
                  state_ff     <= ST_F_RD;
               end
            end
            // right neighbor
            ST_F_RRD: begin
               state_ff <= past_end ? ST_F_WR : ST_F_RCHK;
            end
            ST_F_RCHK: begin
               if (!h_used) begin
                  acc_ff <= POS_W'(SUM_W'(acc_ff) + SUM_W'(HEADER_BYTES) + SUM_W'(h_size));
               end
               state_ff <= ST_F_WR;
            end
            ST_F_WR: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ffbta_pkg::STAT_DONE;
               if (kind_ff == ffbta_pkg::KIND_REALLOC) begin
                  rsp_off_ff  <= new_off_ff;
                  rsp_null_ff <= 1'b0;
               end else begin
                  rsp_off_ff  <= '0;
                  rsp_null_ff <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_offset  = rsp_off_ff;
   assign rsp_result_is_null = rsp_null_ff;

   // checks
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == ffbta_pkg::KIND_ALLOC) |=> busy)
      else $error("allocate did not start");

   a_nonull_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_is_null) |-> (rsp_status != ffbta_pkg::STAT_NOP))
      else $error("offset returned with no-op status");

   a_split_after_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_SPLIT) |-> ($past(state_ff) == ST_A_CHK))
      else $error("split without a marked block");

endmodule

@@ rtl/core/ffbta_hdr_ram.sv @@
// Header store: one write port, one registered read port.
// Depends on nothing; sized by the top level.
module ffbta_hdr_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/tb_first_fit_boundary_tag_allocator.sv @@
// Self-checking testbench for the first-fit boundary-tag allocator.
// Depends on ffbta_pkg and first_fit_boundary_tag_allocator; holds its own
// model of the heap headers and checks every response against it.
`timescale 1ns / 100ps

module tb_first_fit_boundary_tag_allocator;

   localparam int HEAP  = ffbta_pkg::DEF_HEAP_BYTES;
   localparam int ALGN  = ffbta_pkg::DEF_ALIGN_BYTES;
   localparam int HDR   = ffbta_pkg::DEF_HEADER_BYTES;
   localparam int REQ_W = ffbta_pkg::REQ_W;
   localparam int OFF_W = ffbta_pkg::OFF_W;
   localparam int STALL_LIMIT = 20000;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] offset;
      logic             is_null;
   } alloc_resp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]       req_kind = ffbta_pkg::KIND_ALLOC;
   logic [REQ_W-1:0] req_request_bytes = '0;
   logic [OFF_W-1:0] req_block_offset = '0;
   logic             req_block_is_null = 1'b0;
   logic             rsp_valid;
   logic [1:0]       rsp_status;
   logic [OFF_W-1:0] rsp_result_offset;
   logic             rsp_result_is_null;

   first_fit_boundary_tag_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_request_bytes(req_request_bytes),
      .req_block_offset(req_block_offset), .req_block_is_null(req_block_is_null),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_result_offset(rsp_result_offset), .rsp_result_is_null(rsp_result_is_null)
   );

   always #5 clock = ~clock;

   // Heap header image
   bit hdr_used [HEAP];
   int hdr_size [HEAP];
   int hdr_prev [HEAP];

   alloc_resp_type expected_resp_q[$];
   int live_offsets[$];
   int mismatches = 0;
   int sent = 0;
   int received = 0;
   int idle_pct = 37;
   int n_alloc_ok = 0, n_nofit = 0, n_nop = 0;
   int stall_cycles = 0;

   function automatic int block_after(int pos);
      return pos + HDR + hdr_size[pos];
   endfunction

   function automatic void heap_reset();
      foreach (hdr_used[i]) begin
         hdr_used[i] = 1'b0;
         hdr_size[i] = 0;
         hdr_prev[i] = 0;
      end
      hdr_size[0] = HEAP - HDR;
   endfunction

   function automatic void repair_follower(int pos);
      int nxt;
      nxt = block_after(pos);
      if (nxt < HEAP) hdr_prev[nxt] = hdr_size[pos];
   endfunction

   function automatic bit heap_alloc(int req, output int off);
      int need, pos, rem;
      need = ((req + ALGN - 1) / ALGN) * ALGN;
      pos = 0;
      off = 0;
      while (pos < HEAP) begin
         if (!hdr_used[pos] && hdr_size[pos] >= need) begin
            if (hdr_size[pos] > need + HDR) begin
               rem = pos + HDR + need;
               hdr_used[rem] = 1'b0;
               hdr_size[rem] = hdr_size[pos] - need - HDR;
               hdr_prev[rem] = need;
               repair_follower(rem);
               hdr_size[pos] = need;
            end
            hdr_used[pos] = 1'b1;
            off = pos + HDR;
            return 1'b1;
         end
         pos = block_after(pos);
      end
      return 1'b0;
   endfunction

   function automatic bit heap_free(int off);
      int pos, left, first, right;
      bit seen, found;
      pos = 0; left = 0; seen = 0; found = 0;
      while (pos < HEAP && !found) begin
         if (pos + HDR == off) found = 1'b1;
         else begin
            seen = 1'b1;
            left = pos;
            pos = block_after(pos);
         end
      end
      if (!found || !hdr_used[pos]) return 1'b0;
      hdr_used[pos] = 1'b0;
      first = pos;
      right = block_after(pos);
      if (seen && !hdr_used[left]) begin
         hdr_size[left] += HDR + hdr_size[pos];
         first = left;
      end
      if (right < HEAP && !hdr_used[right])
         hdr_size[first] += HDR + hdr_size[right];
      repair_follower(first);
      return 1'b1;
   endfunction

   // Predict the response of one transaction and update the heap image
   function automatic alloc_resp_type predict_alloc(logic [1:0] kind, int req, int boff,
                                                    bit bnull);
      alloc_resp_type r;
      int off;
      r = '{status: ffbta_pkg::STAT_NOP, offset: '0, is_null: 1'b1};
      if (kind == ffbta_pkg::KIND_ALLOC) begin
         if (heap_alloc(req, off)) r = '{ffbta_pkg::STAT_DONE, OFF_W'(off), 1'b0};
         else r.status = ffbta_pkg::STAT_NOFIT;
      end else if (kind == ffbta_pkg::KIND_FREE) begin
         if (!bnull && heap_free(boff)) r.status = ffbta_pkg::STAT_DONE;
      end else if (kind == ffbta_pkg::KIND_REALLOC) begin
         if (heap_alloc(req, off)) begin
            if (!bnull) void'(heap_free(boff));
            r = '{ffbta_pkg::STAT_DONE, OFF_W'(off), 1'b0};
         end else begin
            r.status  = ffbta_pkg::STAT_NOFIT;
            r.offset  = bnull ? '0 : OFF_W'(boff);
            r.is_null = bnull;
         end
      end
      return r;
   endfunction

   // Send one transaction, with random idle cycles before it; start stays
   // high after acceptance until the next idle cycle or drain
   task automatic send_txn(logic [1:0] kind, int req, int boff, bit bnull);
      alloc_resp_type r;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= kind;
      req_request_bytes <= REQ_W'(req);
      req_block_offset  <= OFF_W'(boff);
      req_block_is_null <= bnull;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = predict_alloc(kind, req, boff, bnull);
      expected_resp_q.push_back(r);
      if (r.status == ffbta_pkg::STAT_DONE && kind != ffbta_pkg::KIND_FREE)
         live_offsets.push_back(r.offset);
      sent++;
   endtask

   // Response checker
   always @(posedge clock) begin
      alloc_resp_type e;
      if (!reset && rsp_valid) begin
         received++;
         if (expected_resp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $time);
         end else begin
            e = expected_resp_q.pop_front();
            case (e.status)
               ffbta_pkg::STAT_DONE:  n_alloc_ok++;
               ffbta_pkg::STAT_NOFIT: n_nofit++;
               default:               n_nop++;
            endcase
            if (rsp_status !== e.status || rsp_result_offset !== e.offset ||
                rsp_result_is_null !== e.is_null) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch %0t: exp st=%0d off=%0d null=%0d got st=%0d off=%0d null=%0d",
                           $time, e.status, e.offset, e.is_null, rsp_status,
                           rsp_result_offset, rsp_result_is_null);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted transaction and no response
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic drain();
      start <= 1'b0;
      while (expected_resp_q.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_live();
      if (live_offsets.size() == 0) return HDR;
      return live_offsets[$urandom_range(live_offsets.size() - 1)];
   endfunction

   // Extremes of each field, every kind, the odd cases
   task automatic test_directed();
      int o;
      send_txn(ffbta_pkg::KIND_FREE, 0, HDR, 1'b1);          // free of null
      send_txn(ffbta_pkg::KIND_FREE, 0, HDR, 1'b0);          // free of a free block
      send_txn(ffbta_pkg::KIND_ALLOC, 1024, 0, 1'b0);        // too large
      send_txn(ffbta_pkg::KIND_ALLOC, 2047, 1023, 1'b1);     // all-ones request
      send_txn(ffbta_pkg::KIND_ALLOC, 0, 0, 1'b0);           // zero-size block
      send_txn(ffbta_pkg::KIND_ALLOC, 1, 0, 1'b0);
      send_txn(ffbta_pkg::KIND_ALLOC, 5, 0, 1'b0);
      send_txn(ffbta_pkg::KIND_ALLOC, 3, 0, 1'b0);
      send_txn(ffbta_pkg::KIND_FREE, 0, 13, 1'b0);           // not a block start
      send_txn(ffbta_pkg::KIND_FREE, 0, 1023, 1'b0);
      send_txn(ffbta_pkg::KIND_FREE, 0, 28, 1'b0);           // not a block start either
      send_txn(ffbta_pkg::KIND_FREE, 0, 12, 1'b0);
      send_txn(ffbta_pkg::KIND_FREE, 0, 40, 1'b0);
      send_txn(ffbta_pkg::KIND_REALLOC, 2000, 52, 1'b0);     // realloc fails, echo
      send_txn(ffbta_pkg::KIND_REALLOC, 2000, 52, 1'b1);     // fails, null
      send_txn(ffbta_pkg::KIND_REALLOC, 16, 52, 1'b0);
      send_txn(ffbta_pkg::KIND_REALLOC, 8, 0, 1'b1);
      send_txn(KIND_UNKNOWN, 2047, 1023, 1'b1);              // unknown kind
      send_txn(ffbta_pkg::KIND_ALLOC, 900, 0, 1'b0);
      send_txn(ffbta_pkg::KIND_ALLOC, 1012, 0, 1'b0);
      drain();
      o = pick_live();
      send_txn(ffbta_pkg::KIND_FREE, 0, o, 1'b0);
   endtask

   // Random mix of all kinds, with offsets mostly taken from live blocks
   task automatic test_random(int count);
      int k, req, off;
      bit bnull;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         req = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(120);
         bnull = ($urandom_range(15) == 0);
         if ($urandom_range(9) == 0 || live_offsets.size() == 0) off = $urandom_range(1023);
         else begin
            int idx;
            idx = $urandom_range(live_offsets.size() - 1);
            off = live_offsets[idx];
            live_offsets.delete(idx);
         end
         if (k < 45) send_txn(ffbta_pkg::KIND_ALLOC, req, off, bnull);
         else if (k < 80) send_txn(ffbta_pkg::KIND_FREE, req, off, bnull);
         else if (k < 97) send_txn(ffbta_pkg::KIND_REALLOC, req, off, bnull);
         else send_txn(KIND_UNKNOWN, req, off, bnull);
         if (i == count / 2) begin
            drain();                             // sender waits for all responses
         end
      end
   endtask

   initial begin
      heap_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      idle_pct = 0;                              // back-to-back stretch
      test_random(300);
      idle_pct = 37;
      test_random(330);
      drain();
      repeat (200) @(posedge clock);
      $display("sent %0d transactions, %0d responses: %0d done, %0d no-fit, %0d no-op",
               sent, received, n_alloc_ok, n_nofit, n_nop);
      if (mismatches == 0 && expected_resp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ first_fit_boundary_tag_allocator.f @@
rtl/core/ffbta_pkg.sv
rtl/core/ffbta_hdr_ram.sv
rtl/core/first_fit_boundary_tag_allocator.sv
verif/tb_first_fit_boundary_tag_allocator.sv
